/* sv/psp_pkg.sv */
package psp_pkg;

  // Bus commands carried by one input item
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RD_P2   = 2'd1,
    CMD_RD_P3   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  localparam int unsigned TickW = 6;
  localparam int unsigned PosW  = 5;
  localparam int unsigned DipW  = 6;

  localparam logic [TickW-1:0] TicksPerStep = TickW'(8'h3c);
  localparam logic [PosW-1:0]  SeqLen       = PosW'(8'h1e);

  localparam logic [7:0] WrOff = 8'h00;
  localparam logic [7:0] WrOn  = 8'h01;

  // Requests from the pipeline to the sequence counter
  typedef struct packed {
    logic clear;
    logic tick;
  } seq_ctrl_t;

  // Sequence counter status seen by the read decode
  typedef struct packed {
    logic            prot_off;
    logic [PosW-1:0] pos;
  } seq_stat_t;

  // Port 2 sequence table; positions past the end use entry 0
  function automatic logic [7:0] port2_seq(input logic [PosW-1:0] idx);
    logic [7:0] val;
    case (idx)
      5'd1, 5'd4, 5'd7, 5'd11, 5'd14, 5'd17, 5'd21, 5'd24, 5'd27: val = 8'hc0;
      5'd3, 5'd5, 5'd9, 5'd13, 5'd15, 5'd19, 5'd23, 5'd25, 5'd29: val = 8'h40;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Port 3 sequence table; positions past the end use entry 0
  function automatic logic [7:0] port3_seq(input logic [PosW-1:0] idx);
    logic [7:0] val;
    case (idx)
      5'd1, 5'd7:                 val = 8'h3f;
      5'd2, 5'd3:                 val = 8'h2f;
      5'd4, 5'd5, 5'd6, 5'd8, 5'd9: val = 8'h0f;
      5'd10:                      val = 8'h1c;
      5'd11, 5'd17:               val = 8'h3c;
      5'd12, 5'd13:               val = 8'h2c;
      5'd14, 5'd15, 5'd16, 5'd18, 5'd19: val = 8'h0c;
      5'd20:                      val = 8'h11;
      5'd21, 5'd27:               val = 8'h31;
      5'd22, 5'd23:               val = 8'h21;
      5'd24, 5'd25, 5'd26, 5'd28, 5'd29: val = 8'h01;
      default:                    val = 8'h1f;
    endcase
    return val;
  endfunction

endpackage

/* sv/psp_seq.sv */
module psp_seq
  import psp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_ctrl_t ctrl_i,
  output seq_stat_t stat_o
);

  logic [TickW-1:0] tick_q, tick_d, tick_inc;
  logic [PosW-1:0]  pos_q, pos_d, pos_inc;
  logic             off_q, off_d;

  // Count ticks, step the position every TicksPerStep ticks, wrapping at SeqLen; clear zeroes both and sets prot_off
  always_comb begin
    tick_inc = tick_q + TickW'(1);
    pos_inc  = pos_q + PosW'(1);
    tick_d   = tick_q;
    pos_d    = pos_q;
    off_d    = off_q;
    if (ctrl_i.clear) begin
      tick_d = '0;
      pos_d  = '0;
      off_d  = 1'b1;
    end else if (ctrl_i.tick) begin
      off_d  = 1'b0;
      tick_d = tick_inc;
      if (tick_inc >= TicksPerStep || tick_inc == '0) begin
        tick_d = '0;
        pos_d  = (pos_inc >= SeqLen) ? '0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      pos_q  <= '0;
      off_q  <= 1'b1;
    end else begin
      tick_q <= tick_d;
      pos_q  <= pos_d;
      off_q  <= off_d;
    end
  end

  assign stat_o.prot_off = off_q;
  assign stat_o.pos      = pos_q;

endmodule

/* sv/psp_port_read.sv */
module psp_port_read
  import psp_pkg::*;
(
  input  cmd_e            cmd_i,
  input  logic [5:0]      off_i,
  input  logic [DipW-1:0] dip_i,
  input  seq_stat_t       stat_i,
  output logic [7:0]      data_o
);

  logic [7:0] dip_ext;
  logic [7:0] p2_fixed;
  logic [7:0] p3_fixed;

  assign dip_ext = {2'b00, dip_i};

  // Decode fixed port 2 values from the offset
  always_comb begin
    case (off_i)
      6'h01, 6'h04:        p2_fixed = dip_ext | 8'h40;
      6'h05, 6'h0e, 6'h10: p2_fixed = dip_ext | 8'hc0;
      default:             p2_fixed = dip_ext;
    endcase
  end

  // Decode fixed port 3 values from the offset
  always_comb begin
    case (off_i)
      6'h00:   p3_fixed = 8'h1f;
      6'h09:   p3_fixed = 8'h30;
      6'h0c:   p3_fixed = 8'h00;
      default: p3_fixed = 8'h20;
    endcase
  end

  // Pick the table entry when protection is on, the fixed value when it is off
  always_comb begin
    case (cmd_i)
      CMD_RD_P2: data_o = stat_i.prot_off ? p2_fixed : (port2_seq(stat_i.pos) | dip_ext);
      CMD_RD_P3: data_o = stat_i.prot_off ? p3_fixed : port3_seq(stat_i.pos);
      default:   data_o = 8'h00;
    endcase
  end

endmodule

/* sv/protection_sequence_ports.sv */
// Channel   Handshake                      Payload
// in        in_valid_i / in_stall_o        command_i, write_value_i, port_offset_i
// out       out_valid_o / out_stall_i      read_value_o
// cfg       cfg_we_i                       cfg_wdata_i (dip switches)
//
// One item per cycle sustained while the output is not stalled; a read's byte is
// held in the input register and then in the result register, around the decode.
// Writes produce no output and retire from the input register.
// Reset (rst_ni low, async) leaves protection off, counter and position at zero.
// A stalled output holds its byte; the input register keeps accepting until it
// too is blocked behind the stalled result.
module protection_sequence_ports
  import psp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] write_value_i,
  input  logic [5:0] port_offset_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_value_o,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i
);

  logic            s1_valid_q, s1_valid_d;
  cmd_e            s1_cmd_q;
  logic [7:0]      s1_wv_q;
  logic [5:0]      s1_off_q;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_data_q;
  logic [DipW-1:0] dip_q;
  logic            s1_adv, s1_fire, in_xfer, s1_is_read;
  seq_ctrl_t       ctrl;
  seq_stat_t       stat;
  logic [7:0]      rd_data;

  // Handshake control
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign s1_is_read = (s1_cmd_q == CMD_RD_P2) || (s1_cmd_q == CMD_RD_P3);

  // Control register writes act when the item leaves the input register
  assign ctrl.clear = s1_fire && (s1_cmd_q == CMD_WRITE) && (s1_wv_q == WrOff);
  assign ctrl.tick  = s1_fire && (s1_cmd_q == CMD_WRITE) && (s1_wv_q == WrOn);

  psp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  psp_port_read u_rd (
    .cmd_i  (s1_cmd_q),
    .off_i  (s1_off_q),
    .dip_i  (dip_q),
    .stat_i (stat),
    .data_o (rd_data)
  );

  // Hold dip switch setting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_q <= '0;
    end else if (cfg_we_i) begin
      dip_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q <= cmd_e'(command_i);
      s1_wv_q  <= write_value_i;
      s1_off_q <= port_offset_i;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_is_read) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_is_read) begin
      out_data_q <= rd_data;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_data_q;

endmodule

/* sv/psp_checker.sv */
module psp_checker
  import psp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] command_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_value_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(read_value_o))
    else $error("output data changed while stalled");

  // Input backpressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  // A fresh result follows a read transfer, by way of the input register
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o &&
      (command_i == CMD_RD_P2 || command_i == CMD_RD_P3), 2))
    else $error("result appeared without a matching read");

endmodule

bind protection_sequence_ports psp_checker u_psp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .command_i    (command_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o)
);
